// ===== rtl/ip565_pkg.sv =====
package ip565_pkg;

    // Default sizes handed to the top level
    localparam int DEF_MAX_WIDTH       = 4096;
    localparam int DEF_PALETTE_ENTRIES = 256;

    // Field widths fixed by the interface
    localparam int CMD_W    = 1;
    localparam int BYTE_W   = 8;
    localparam int DWORD_W  = 24;
    localparam int PIX_W    = 16;
    localparam int MODE_W   = 3;
    localparam int RWIDTH_W = 13;
    localparam int CFG_A_W  = 1;
    localparam int CFG_D_W  = 13;
    localparam int SUB_W    = 3;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PAL_WRITE = 1'b0;
    localparam logic [CMD_W-1:0] CMD_ROW_DATA  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_A_W-1:0] CFG_DEPTH_MODE = 1'b0;
    localparam logic [CFG_A_W-1:0] CFG_ROW_WIDTH  = 1'b1;

    // Source pixel formats
    localparam logic [MODE_W-1:0] DM_BIT1      = 3'd0;
    localparam logic [MODE_W-1:0] DM_BIT4_PACK = 3'd1;
    localparam logic [MODE_W-1:0] DM_BIT4_LOW  = 3'd2;
    localparam logic [MODE_W-1:0] DM_BIT8      = 3'd3;
    localparam logic [MODE_W-1:0] DM_RGB565    = 3'd4;
    localparam logic [MODE_W-1:0] DM_BGR24     = 3'd5;

    // One result item on its way out
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last_of_item;
        logic             row_end;
    } t_out_item;

    // Reduce 8-bit components to RGB565
    function automatic logic [PIX_W-1:0] pack565(
        input logic [BYTE_W-1:0] red,
        input logic [BYTE_W-1:0] green,
        input logic [BYTE_W-1:0] blue
    );
        return {red[7:3], green[7:2], blue[7:3]};
    endfunction

endpackage

// ===== rtl/ip565_ram.sv =====
module ip565_ram
    import ip565_pkg::*;
#(
    parameter int WIDTH = PIX_W,
    parameter int DEPTH = DEF_PALETTE_ENTRIES
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/indexed_pixel_to_rgb565.sv =====
// Indexed/direct pixel to RGB565 converter. Each input item is either a palette write
// (tuser = 0), which stores one entry reduced to 5/6/5 bits and yields no pixel, or one
// step of row data (tuser = 1) expanded per depth_mode into 0 to 8 RGB565 pixels. One
// pixel leaves per cycle while the output queue has room. The single read port of the
// palette RAM, one look-up per cycle, sets that pace. A pixel passes the RAM read
// register, then a two-entry output queue, and the next item is taken in the same cycle
// as the last pixel of the current one. Row width is clamped to 1..MAX_WIDTH; tlast marks
// the pixel that ends a row, tuser the last pixel of an item. Configuration writes belong
// in idle periods.
module indexed_pixel_to_rgb565
    import ip565_pkg::*;
#(
    parameter int MAX_WIDTH       = DEF_MAX_WIDTH,
    parameter int PALETTE_ENTRIES = DEF_PALETTE_ENTRIES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_A_W-1:0]   i_cfg_addr,
    input  logic [CFG_D_W-1:0]   i_cfg_data,
    // input items
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // palette_index[7:0], pal_red[15:8], pal_green[23:16], pal_blue[31:24],
    // data_word[55:32]
    input  logic [55:0]          s_axis_tdata,
    // command[0]
    input  logic [CMD_W-1:0]     s_axis_tuser,
    // result items
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // pixel[15:0]
    output logic [PIX_W-1:0]     m_axis_tdata,
    // last_of_item[0]
    output logic                 m_axis_tuser,
    // row_end
    output logic                 m_axis_tlast
);

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int AW = $clog2(PALETTE_ENTRIES);

    // ---------------------------------------------------------------
    // Configuration
    logic [MODE_W-1:0] r_depth_mode;
    logic [CW-1:0]     r_weff;
    logic [CW-1:0]     n_weff;
    logic [RWIDTH_W-1:0] cfg_rw;

    // effective width: zero taken as 1, saturated at MAX_WIDTH
    always_comb begin
        cfg_rw = i_cfg_data[RWIDTH_W-1:0];
        if (cfg_rw == '0) begin
            n_weff = CW'(1);
        end else if (32'(cfg_rw) > 32'(MAX_WIDTH)) begin
            n_weff = CW'(MAX_WIDTH);
        end else begin
            n_weff = CW'(cfg_rw);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_mode <= DM_BIT8;
            r_weff       <= CW'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_DEPTH_MODE: r_depth_mode <= i_cfg_data[MODE_W-1:0];
                CFG_ROW_WIDTH:  r_weff       <= n_weff;
                default:        ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Expander stage: holds one input item, emits one pixel per cycle while downstream has room
    logic                r_a_valid;
    logic [CMD_W-1:0]    r_a_cmd;
    logic [BYTE_W-1:0]   r_a_index;
    logic [BYTE_W-1:0]   r_a_red;
    logic [BYTE_W-1:0]   r_a_green;
    logic [BYTE_W-1:0]   r_a_blue;
    logic [DWORD_W-1:0]  r_a_data;
    logic [SUB_W-1:0]    r_sub;
    logic [CW-1:0]       r_col;

    logic                in_accept;
    logic                a_done;
    logic                issue;
    logic                issue_ok;
    logic                pop;
    logic [1:0]          occ;

    logic [BYTE_W-1:0]   b0;
    logic [BYTE_W-1:0]   b1;
    logic [BYTE_W-1:0]   b2;
    logic [BYTE_W-1:0]   pix_idx;
    logic                use_pal;
    logic [PIX_W-1:0]    direct;
    logic [SUB_W-1:0]    kmax;
    logic                mode_ok;
    logic                pix_last;
    logic [CW-1:0]       col_cur;
    logic [CW-1:0]       col_nxt;
    logic                col_end;
    logic                pal_we;

    assign b0 = r_a_data[7:0];
    assign b1 = r_a_data[15:8];
    assign b2 = r_a_data[23:16];

    // pixel select per depth mode
    always_comb begin
        pix_idx = '0;
        use_pal = 1'b0;
        direct  = '0;
        kmax    = '0;
        mode_ok = 1'b1;
        unique case (r_depth_mode)
            DM_BIT1: begin
                pix_idx = {7'b0, b0[3'd7 - r_sub]};
                use_pal = 1'b1;
                kmax    = SUB_W'(7);
            end
            DM_BIT4_PACK: begin
                pix_idx = (r_sub == '0) ? {4'b0, b0[7:4]} : {4'b0, b0[3:0]};
                use_pal = 1'b1;
                kmax    = SUB_W'(1);
            end
            DM_BIT4_LOW: begin
                pix_idx = {4'b0, b0[3:0]};
                use_pal = 1'b1;
            end
            DM_BIT8: begin
                pix_idx = b0;
                use_pal = 1'b1;
            end
            DM_RGB565: direct  = {b1, b0};
            DM_BGR24:  direct  = pack565(b2, b1, b0);
            default:   mode_ok = 1'b0;
        endcase
        // look-up past the palette reads as pixel 0
        if (use_pal && ({1'b0, pix_idx} >= 9'(PALETTE_ENTRIES))) begin
            use_pal = 1'b0;
            direct  = '0;
        end
    end

    // column counter step; a count at or past the width restarts the row
    always_comb begin
        col_cur  = (r_col >= r_weff) ? '0 : r_col;
        col_nxt  = col_cur + CW'(1);
        col_end  = (col_nxt >= r_weff);
        pix_last = (r_sub == kmax) || col_end;
    end

    // downstream room: RAM read in flight plus queued results
    assign pop      = m_axis_tvalid && m_axis_tready;
    assign issue_ok = (occ < 2'd2) || pop;
    assign issue    = r_a_valid && (r_a_cmd == CMD_ROW_DATA) && mode_ok && issue_ok;
    assign pal_we   = r_a_valid && (r_a_cmd == CMD_PAL_WRITE) &&
                      ({1'b0, r_a_index} < 9'(PALETTE_ENTRIES));

    assign a_done = r_a_valid &&
                    ((r_a_cmd == CMD_PAL_WRITE) || !mode_ok || (issue && pix_last));

    assign s_axis_tready = !r_a_valid || a_done;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_sub     <= '0;
            r_col     <= '0;
        end else begin
            if (in_accept) begin
                r_a_valid <= 1'b1;
            end else if (a_done) begin
                r_a_valid <= 1'b0;
            end
            if (in_accept) begin
                r_sub <= '0;
            end else if (issue && !pix_last) begin
                r_sub <= r_sub + SUB_W'(1);
            end
            if (issue) begin
                r_col <= col_end ? '0 : col_nxt;
            end
        end
    end

    // item payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_a_cmd   <= s_axis_tuser;
            r_a_index <= s_axis_tdata[7:0];
            r_a_red   <= s_axis_tdata[15:8];
            r_a_green <= s_axis_tdata[23:16];
            r_a_blue  <= s_axis_tdata[31:24];
            r_a_data  <= s_axis_tdata[55:32];
        end
    end

    // ---------------------------------------------------------------
    // Palette RAM
    logic [PIX_W-1:0] ram_rdata;

    ip565_ram #(
        .WIDTH (PIX_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (pal_we),
        .i_waddr (r_a_index[AW-1:0]),
        .i_wdata (pack565(r_a_red, r_a_green, r_a_blue)),
        .i_re    (issue && use_pal),
        .i_raddr (pix_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // ---------------------------------------------------------------
    // Read stage: pixel waiting on the RAM read
    logic             r_b_valid;
    logic             r_b_use_pal;
    logic [PIX_W-1:0] r_b_direct;
    logic             r_b_last;
    logic             r_b_end;
    t_out_item        b_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_b_use_pal <= use_pal;
            r_b_direct  <= direct;
            r_b_last    <= pix_last;
            r_b_end     <= col_end;
        end
    end

    always_comb begin
        b_item.pixel        = r_b_use_pal ? ram_rdata : r_b_direct;
        b_item.last_of_item = r_b_last;
        b_item.row_end      = r_b_end;
    end

    // ---------------------------------------------------------------
    // Two-entry output queue
    t_out_item  r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_q_cnt;

    assign occ = r_q_cnt + {1'b0, r_b_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_q_cnt  <= '0;
        end else begin
            if (r_b_valid) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_q_cnt <= r_q_cnt + {1'b0, r_b_valid} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            r_q[r_wr_ptr] <= b_item;
        end
    end

    assign m_axis_tvalid = (r_q_cnt != '0);
    assign m_axis_tdata  = r_q[r_rd_ptr].pixel;
    assign m_axis_tuser  = r_q[r_rd_ptr].last_of_item;
    assign m_axis_tlast  = r_q[r_rd_ptr].row_end;

    // ---------------------------------------------------------------
    // Checks
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_q_cnt + {1'b0, r_b_valid}) <= 2'd2)
        else $error("output queue overcommitted");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> (r_q_cnt != 2'd2))
        else $error("RAM result with full output queue");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser)
        else $error("row end not flagged as last pixel of item");

    a_sub_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && (r_depth_mode == DM_BIT4_PACK)) |-> (r_sub <= SUB_W'(1)))
        else $error("4-bit packed item past its second pixel");

endmodule

// ===== sim/rgb565_pixel_checker.sv =====
// Watches the configuration port and both streams of the converter, keeps its own
// palette, format and column state, and compares every pixel with the oldest one due.
module rgb565_pixel_checker
    import ip565_pkg::*;
#(
    parameter int MAX_WIDTH       = DEF_MAX_WIDTH,
    parameter int PALETTE_ENTRIES = DEF_PALETTE_ENTRIES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_A_W-1:0]   i_cfg_addr,
    input  logic [CFG_D_W-1:0]   i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    // palette_index[7:0], pal_red[15:8], pal_green[23:16], pal_blue[31:24],
    // data_word[55:32]
    input  logic [55:0]          i_in_data,
    // command[0]
    input  logic [CMD_W-1:0]     i_in_user,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    // pixel[15:0]
    input  logic [PIX_W-1:0]     i_out_data,
    // last_of_item[0]
    input  logic                 i_out_user,
    input  logic                 i_out_last,
    output int                   o_errors,
    output int                   o_pending,
    output int                   o_checked
);

    // Model state: palette already in 5/6/5 form, format registers, column position
    logic [PIX_W-1:0]    palette [PALETTE_ENTRIES];
    logic [MODE_W-1:0]   depth;
    logic [RWIDTH_W-1:0] row_width;
    int                  column;
    t_out_item           pixels_due[$];
    t_out_item           seen;
    t_out_item           due;

    function automatic logic [PIX_W-1:0] reduce_rgb(input logic [7:0] red,
                                                    input logic [7:0] green,
                                                    input logic [7:0] blue);
        return {red[7:3], green[7:2], blue[7:3]};
    endfunction

    function automatic logic [PIX_W-1:0] palette_lookup(input int idx);
        if (idx >= PALETTE_ENTRIES)
            return '0;
        return palette[idx];
    endfunction

    // Work out the pixels one input item produces and queue them
    task automatic expand_item(input logic [CMD_W-1:0] cmd, input logic [55:0] word);
        logic [7:0]       b0;
        logic [7:0]       b1;
        logic [7:0]       b2;
        logic [PIX_W-1:0] px [8];
        int               n;
        int               width;
        int               remaining;
        t_out_item        pix;
        b0 = word[39:32];
        b1 = word[47:40];
        b2 = word[55:48];
        if (cmd == CMD_PAL_WRITE) begin
            if (int'(word[7:0]) < PALETTE_ENTRIES)
                palette[word[7:0]] = reduce_rgb(word[15:8], word[23:16], word[31:24]);
            return;
        end
        // clamp the row width, start a new row if the width was lowered under us
        width = (row_width == '0) ? 1 : int'(row_width);
        if (width > MAX_WIDTH)
            width = MAX_WIDTH;
        if (column >= width)
            column = 0;
        remaining = width - column;
        n = 0;
        case (depth)
            DM_BIT1: begin
                for (int k = 0; k < 8; k++)
                    px[k] = palette_lookup(int'(b0[7-k]));
                n = (remaining < 8) ? remaining : 8;
            end
            DM_BIT4_PACK: begin
                px[0] = palette_lookup(int'(b0[7:4]));
                px[1] = palette_lookup(int'(b0[3:0]));
                n = (remaining < 2) ? remaining : 2;
            end
            DM_BIT4_LOW: begin
                px[0] = palette_lookup(int'(b0[3:0]));
                n = 1;
            end
            DM_BIT8: begin
                px[0] = palette_lookup(int'(b0));
                n = 1;
            end
            DM_RGB565: begin
                px[0] = {b1, b0};
                n = 1;
            end
            DM_BGR24: begin
                px[0] = reduce_rgb(b2, b1, b0);
                n = 1;
            end
            default: n = 0;
        endcase
        for (int k = 0; k < n; k++) begin
            column++;
            pix.pixel        = px[k];
            pix.last_of_item = (k == n - 1);
            pix.row_end      = (column >= width);
            if (pix.row_end)
                column = 0;
            pixels_due.push_back(pix);
        end
    endtask

    task automatic report(input string what);
        o_errors++;
        if (o_errors <= 10)
            $display("%s: expected pixel %h last_of_item %b row_end %b, got %h %b %b",
                     what, due.pixel, due.last_of_item, due.row_end,
                     seen.pixel, seen.last_of_item, seen.row_end);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            depth     = DM_BIT8;
            row_width = RWIDTH_W'(1);
            column    = 0;
            pixels_due.delete();
            o_errors  = 0;
            o_checked = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_DEPTH_MODE: depth = i_cfg_data[MODE_W-1:0];
                    CFG_ROW_WIDTH:  row_width = i_cfg_data[RWIDTH_W-1:0];
                    default: ;
                endcase
            end
            // results first: a pixel can never stem from an item taken at this edge
            if (i_out_valid && i_out_ready) begin
                seen.pixel        = i_out_data;
                seen.last_of_item = i_out_user;
                seen.row_end      = i_out_last;
                o_checked++;
                if (pixels_due.size() == 0) begin
                    due = 'x;
                    report("pixel with nothing due");
                end else begin
                    due = pixels_due.pop_front();
                    if (seen !== due)
                        report("pixel mismatch");
                end
            end
            if (i_in_valid && i_in_ready)
                expand_item(i_in_user, i_in_data);
        end
        o_pending = pixels_due.size();
    end

endmodule

// ===== sim/tb_indexed_pixel_to_rgb565.sv =====
module tb_indexed_pixel_to_rgb565;
    import ip565_pkg::*;

    localparam int ITEM_GOAL  = 280;
    localparam int CALM_AFTER = 230;      // no idling from here on
    localparam int RUN_LIMIT  = 200000;
    localparam int DRAIN_WAIT = 12;       // pipeline depth plus margin

    // formats the block does not implement
    localparam logic [MODE_W-1:0] DM_SPARE6 = 3'd6;
    localparam logic [MODE_W-1:0] DM_SPARE7 = 3'd7;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_A_W-1:0]   i_cfg_addr = CFG_DEPTH_MODE;
    logic [CFG_D_W-1:0]   i_cfg_data = '0;
    logic                 s_valid    = 1'b0;
    logic [55:0]          s_data     = '0;
    logic [CMD_W-1:0]     s_user     = CMD_PAL_WRITE;
    logic                 m_ready    = 1'b1;
    logic                 s_ready;
    logic                 m_valid;
    logic [PIX_W-1:0]     m_data;
    logic                 m_user;
    logic                 m_last;

    int                   errors;
    int                   pending;
    int                   checked;
    int                   cycles        = 0;
    int                   items_sent    = 0;
    int                   pal_writes    = 0;
    int                   row_items     = 0;
    int                   formats_used  = 0;
    int                   gap_odds      = 4;
    bit                   allow_gaps    = 1'b1;
    bit                   pal_written [256];
    logic [MODE_W-1:0]    cur_mode      = DM_BIT8;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    indexed_pixel_to_rgb565 dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_user),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tuser  (m_user),
        .m_axis_tlast  (m_last)
    );

    rgb565_pixel_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (s_valid),
        .i_in_ready  (s_ready),
        .i_in_data   (s_data),
        .i_in_user   (s_user),
        .i_out_valid (m_valid),
        .i_out_ready (m_ready),
        .i_out_data  (m_data),
        .i_out_user  (m_user),
        .i_out_last  (m_last),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > RUN_LIMIT) begin
            $display("indexed_pixel_to_rgb565 regression: fail");
            $finish;
        end
    end

    // Pixel sink: random stall bursts while idling is allowed
    initial begin
        forever begin
            if (allow_gaps && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
    end

    // Offer one item, return at the edge that takes it
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [55:0] payload);
        if (allow_gaps && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= payload;
        s_user  <= cmd;
        do @(posedge i_clk); while (!s_ready);
        items_sent++;
        if (cmd == CMD_PAL_WRITE)
            pal_writes++;
        else
            row_items++;
    endtask

    task automatic write_palette(input logic [7:0] idx, input logic [7:0] red,
                                 input logic [7:0] green, input logic [7:0] blue);
        send_item(CMD_PAL_WRITE, {24'($urandom), blue, green, red, idx});
        pal_written[idx] = 1'b1;
    endtask

    task automatic send_row(input logic [23:0] word);
        send_item(CMD_ROW_DATA, {word, 32'($urandom)});
    endtask

    // Hold off until every pixel is out and the block has gone quiet
    task automatic drain();
        s_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // Register writes, back to back, only while idle
    task automatic set_format(input logic [MODE_W-1:0] mode, input logic [RWIDTH_W-1:0] width,
                              input bit wr_mode, input bit wr_width);
        if (wr_mode) begin
            i_cfg_we   <= 1'b1;
            i_cfg_addr <= CFG_DEPTH_MODE;
            i_cfg_data <= CFG_D_W'(mode);
            cur_mode    = mode;
            @(posedge i_clk);
        end
        if (wr_width) begin
            i_cfg_we   <= 1'b1;
            i_cfg_addr <= CFG_ROW_WIDTH;
            i_cfg_data <= CFG_D_W'(width);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        formats_used++;
    endtask

    // Random palette index below span that has already been stored
    function automatic logic [7:0] written_index(input int span);
        int idx;
        idx = $urandom_range(0, span - 1);
        while (!pal_written[idx])
            idx = $urandom_range(0, span - 1);
        return 8'(idx);
    endfunction

    // Random row data whose palette look-ups only hit stored entries
    function automatic logic [23:0] row_word(input logic [MODE_W-1:0] mode);
        logic [23:0] word;
        logic [7:0]  hi_idx;
        logic [7:0]  lo_idx;
        word   = 24'($urandom);
        hi_idx = written_index(16);
        lo_idx = written_index(16);
        case (mode)
            DM_BIT4_PACK: word[7:0] = {hi_idx[3:0], lo_idx[3:0]};
            DM_BIT4_LOW:  word[3:0] = lo_idx[3:0];
            DM_BIT8:      word[7:0] = written_index(256);
            default: ;
        endcase
        return word;
    endfunction

    initial begin
        int                  pick;
        int                  phase_len;
        logic [MODE_W-1:0]   mode;
        logic [RWIDTH_W-1:0] width;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: palette extremes, then every format at its corner widths
        write_palette(8'd0, 8'h00, 8'h00, 8'h00);
        write_palette(8'd1, 8'hFF, 8'hFF, 8'hFF);
        write_palette(8'd15, 8'hFF, 8'h00, 8'h80);
        write_palette(8'd255, 8'h80, 8'hFC, 8'hF8);
        drain();
        // 1-bit: a full byte, then a byte cut short by the row end
        set_format(DM_BIT1, 13'd11, 1'b1, 1'b1);
        send_row(24'h0000A5);
        send_row(24'hFFFF5A);
        drain();
        // packed nibbles: second nibble dropped at the row end
        set_format(DM_BIT4_PACK, 13'd3, 1'b1, 1'b1);
        send_row(24'h0000F0);
        send_row(24'h00000F);
        drain();
        // low nibble only, width zero acts as one
        set_format(DM_BIT4_LOW, 13'd0, 1'b1, 1'b1);
        send_row(24'h0000FF);
        send_row(24'hFFFFF0);
        drain();
        // pass-through with an oversized width
        set_format(DM_RGB565, 13'h1FFF, 1'b1, 1'b1);
        send_row(24'h00FFFF);
        send_row(24'hFF0000);
        drain();
        set_format(DM_BGR24, 13'd4096, 1'b1, 1'b1);
        send_row(24'hFFFFFF);
        send_row(24'h000000);
        drain();
        // unused formats yield nothing
        set_format(DM_SPARE6, 13'd4096, 1'b1, 1'b0);
        send_row(24'($urandom));
        drain();
        set_format(DM_SPARE7, 13'd4096, 1'b1, 1'b0);
        send_row(24'($urandom));
        drain();
        // width dropped below the column in mid-row: a fresh row starts
        set_format(DM_BIT8, 13'd2, 1'b1, 1'b1);
        send_row(24'h0000FF);
        send_row(24'hFFFF00);
        send_row(24'h000001);

        // Random phases: new format, then a burst of rows mixed with palette writes
        while (items_sent < ITEM_GOAL) begin
            drain();
            if (items_sent >= CALM_AFTER)
                allow_gaps = 1'b0;
            pick = $urandom_range(0, 15);
            mode = (pick < 14) ? MODE_W'(pick % 6) : ((pick == 14) ? DM_SPARE6 : DM_SPARE7);
            case ($urandom_range(0, 9))
                0:       width = 13'd0;
                1:       width = 13'd4096;
                2:       width = 13'h1FFF;
                3:       width = RWIDTH_W'($urandom_range(4097, 8191));
                4:       width = 13'd1;
                default: width = RWIDTH_W'($urandom_range(2, 40));
            endcase
            set_format(mode, width, $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0);
            gap_odds  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 6);
            phase_len = $urandom_range(6, 24);
            repeat (phase_len) begin
                if ($urandom_range(0, 4) == 0)
                    write_palette($urandom_range(0, 1) ? 8'($urandom_range(0, 15))
                                                       : 8'($urandom_range(0, 255)),
                                  8'($urandom), 8'($urandom), 8'($urandom));
                else
                    send_row(row_word(cur_mode));
            end
        end
        drain();

        $display("covered %0d items (%0d palette writes, %0d row-data items) over %0d formats",
                 items_sent, pal_writes, row_items, formats_used);
        $display("%0d pixels compared, %0d mismatches, %0d still due", checked, errors, pending);
        if (errors == 0 && pending == 0)
            $display("indexed_pixel_to_rgb565 regression: pass");
        else
            $display("indexed_pixel_to_rgb565 regression: fail");
        $finish;
    end

endmodule

// ===== indexed_pixel_to_rgb565.f =====
rtl/ip565_pkg.sv
rtl/ip565_ram.sv
rtl/indexed_pixel_to_rgb565.sv
sim/rgb565_pixel_checker.sv
sim/tb_indexed_pixel_to_rgb565.sv
